>>> hw/rtl/tvsf_pkg.sv
// ----------------------------------------------------------------------------
// Value scan filter package
// Register indexes, compare mode codes, width codes, the configuration
// struct and the helpers that mask and order operands.
// ----------------------------------------------------------------------------
`default_nettype none

package tvsf_pkg;

   // Configuration port
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = 64;

   localparam logic [CsrIndexBits-1:0] REG_SCAN_MODE    = 3'd0;
   localparam logic [CsrIndexBits-1:0] REG_VALUE_WIDTH  = 3'd1;
   localparam logic [CsrIndexBits-1:0] REG_VALUE_SIGNED = 3'd2;
   localparam logic [CsrIndexBits-1:0] REG_FIRST_VALUE  = 3'd3;
   localparam logic [CsrIndexBits-1:0] REG_SECOND_VALUE = 3'd4;

   // Compare modes
   localparam logic [3:0] MODE_EQUAL        = 4'd0;
   localparam logic [3:0] MODE_BIGGER       = 4'd1;
   localparam logic [3:0] MODE_SMALLER      = 4'd2;
   localparam logic [3:0] MODE_RANGE        = 4'd3;
   localparam logic [3:0] MODE_INCREASED    = 4'd4;
   localparam logic [3:0] MODE_INCREASED_BY = 4'd5;
   localparam logic [3:0] MODE_DECREASED    = 4'd6;
   localparam logic [3:0] MODE_DECREASED_BY = 4'd7;
   localparam logic [3:0] MODE_CHANGED      = 4'd8;
   localparam logic [3:0] MODE_UNCHANGED    = 4'd9;
   localparam logic [3:0] MODE_UNKNOWN      = 4'd10;

   // Operand widths
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   localparam logic [63:0] KEY_FLIP = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [3:0]  scan_mode;
      logic [1:0]  value_width;
      logic        value_signed;
      logic [63:0] first_value;
      logic [63:0] second_value;
   } cfg_type;

   // Mask that keeps the low bits of the selected width
   function automatic logic [63:0] width_mask(input logic [1:0] width_code);
      logic [63:0] mask;
      case (width_code)
         WIDTH_8:  mask = 64'h0000_0000_0000_00FF;
         WIDTH_16: mask = 64'h0000_0000_0000_FFFF;
         WIDTH_32: mask = 64'h0000_0000_FFFF_FFFF;
         default:  mask = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return mask;
   endfunction

   // Map a masked value to a key whose unsigned order is the selected order
   function automatic logic [63:0] order_key(input logic [63:0] value,
                                             input logic [63:0] mask,
                                             input logic        is_signed);
      logic [63:0] sign_bit;
      logic [63:0] key;
      sign_bit = (mask >> 1) + 64'd1;
      key      = value;
      if (is_signed) begin
         if ((key & sign_bit) != 64'd0) begin
            key = key | ~mask;
         end
         key = key ^ KEY_FLIP;
      end
      return key;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/typed_value_scan_filter_top.sv
// ----------------------------------------------------------------------------
// Typed value scan filter
// Compares one candidate word per item against references or its previous
// value at a configured width and order, and returns match, address and
// the width-masked current value.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata (low bit up)                      | tuser
//  --------+-----------+-----------------------------------------+-------------
//  req_    | in        | address, current_word, previous_word    | has_previous
//  rsp_    | out       | match_address, kept_value               | match
//  csr_    | in        | write enable, register index, data      | -
//
//  One item enters per cycle while rsp_ is not stalled. An item moves through
//  three register stages (mask and key, compare, mode select into the output
//  register), and its result is offered on rsp_ from the output register.
//  Each stage holds its item while the next one is full and blocked, so a
//  stall on rsp_ backs up stage by stage and bubbles are still filled.
//  reset is synchronous and empties all stages and loads register defaults.
//  Write configuration only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_value_scan_filter_top #(
   parameter  int ADDRESS_BITS = 48,
   localparam int ReqDataBits  = ((ADDRESS_BITS + 128 + 7) / 8) * 8,
   localparam int RspDataBits  = ((ADDRESS_BITS + 64 + 7) / 8) * 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input channel
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // address, current_word, previous_word
   input  wire logic [ReqDataBits-1:0]             req_tdata,
   // has_previous
   input  wire logic                               req_tuser,
   // result channel
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // match_address, kept_value
   output      logic [RspDataBits-1:0]             rsp_tdata,
   // match
   output      logic                               rsp_tuser,
   // configuration port
   input  wire logic                               csr_wen,
   input  wire logic [tvsf_pkg::CsrIndexBits-1:0]  csr_index,
   input  wire logic [tvsf_pkg::CsrDataBits-1:0]   csr_wdata
);
   import tvsf_pkg::*;

   typedef struct packed {
      logic [ADDRESS_BITS-1:0] address;
      logic [63:0]             cur;
      logic [63:0]             first;
      logic [63:0]             key_cur;
      logic [63:0]             key_prev;
      logic [63:0]             key_first;
      logic [63:0]             key_second;
      logic [63:0]             diff_up;
      logic [63:0]             diff_down;
      logic                    has_prev;
   } s1_type;

   typedef struct packed {
      logic [ADDRESS_BITS-1:0] address;
      logic [63:0]             cur;
      logic                    has_prev;
      logic                    eq_first;
      logic                    gt_first;
      logic                    lt_first;
      logic                    lt_second;
      logic                    gt_prev;
      logic                    lt_prev;
      logic                    eq_prev;
      logic                    up_hit;
      logic                    down_hit;
   } s2_type;

   cfg_type cfg;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   logic [ADDRESS_BITS-1:0] s3_address_ff, s3_address_in;
   logic [63:0]             s3_kept_ff, s3_kept_in;
   logic                    s3_match_ff, s3_match_in;

   logic s1_ready, s2_ready, s3_ready;
   logic [63:0] mask;
   logic [63:0] cur_raw, prev_raw;
   logic        match_sel;

   tvsf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Per-stage ready: a stage takes an item when empty or draining
   assign s3_ready   = !s3_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   // Stage 1: mask operands, build order keys, wrap the differences
   assign mask     = width_mask(cfg.value_width);
   assign cur_raw  = req_tdata[ADDRESS_BITS +: 64];
   assign prev_raw = req_tdata[ADDRESS_BITS + 64 +: 64];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (s1_ready) begin
         s1_valid_in      = req_tvalid;
         s1_in.address    = req_tdata[ADDRESS_BITS-1:0];
         s1_in.cur        = cur_raw & mask;
         s1_in.first      = cfg.first_value & mask;
         s1_in.key_cur    = order_key(cur_raw & mask, mask, cfg.value_signed);
         s1_in.key_prev   = order_key(prev_raw & mask, mask, cfg.value_signed);
         s1_in.key_first  = order_key(cfg.first_value & mask, mask, cfg.value_signed);
         s1_in.key_second = order_key(cfg.second_value & mask, mask, cfg.value_signed);
         s1_in.diff_up    = (cur_raw - prev_raw) & mask;
         s1_in.diff_down  = (prev_raw - cur_raw) & mask;
         s1_in.has_prev   = req_tuser;
      end
   end

   // Stage 2: all compares in parallel, one wide compare each
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_in       = s2_ff;
      if (s2_ready) begin
         s2_valid_in     = s1_valid_ff;
         s2_in.address   = s1_ff.address;
         s2_in.cur       = s1_ff.cur;
         s2_in.has_prev  = s1_ff.has_prev;
         s2_in.eq_first  = s1_ff.key_cur == s1_ff.key_first;
         s2_in.gt_first  = s1_ff.key_cur >  s1_ff.key_first;
         s2_in.lt_first  = s1_ff.key_cur <  s1_ff.key_first;
         s2_in.lt_second = s1_ff.key_cur <  s1_ff.key_second;
         s2_in.gt_prev   = s1_ff.key_cur >  s1_ff.key_prev;
         s2_in.lt_prev   = s1_ff.key_cur <  s1_ff.key_prev;
         s2_in.eq_prev   = s1_ff.key_cur == s1_ff.key_prev;
         s2_in.up_hit    = s1_ff.diff_up == s1_ff.first;
         s2_in.down_hit  = s1_ff.diff_down == s1_ff.first;
      end
   end

   // Stage 3: pick the flag for the mode; modes on the previous value need it
   always_comb begin
      case (cfg.scan_mode)
         MODE_EQUAL:        match_sel = s2_ff.eq_first;
         MODE_BIGGER:       match_sel = s2_ff.gt_first;
         MODE_SMALLER:      match_sel = s2_ff.lt_first;
         MODE_RANGE:        match_sel = s2_ff.gt_first && s2_ff.lt_second;
         MODE_INCREASED:    match_sel = s2_ff.has_prev && s2_ff.gt_prev;
         MODE_INCREASED_BY: match_sel = s2_ff.has_prev && s2_ff.up_hit;
         MODE_DECREASED:    match_sel = s2_ff.has_prev && s2_ff.lt_prev;
         MODE_DECREASED_BY: match_sel = s2_ff.has_prev && s2_ff.down_hit;
         MODE_CHANGED:      match_sel = s2_ff.has_prev && !s2_ff.eq_prev;
         MODE_UNCHANGED:    match_sel = s2_ff.has_prev && s2_ff.eq_prev;
         MODE_UNKNOWN:      match_sel = 1'b1;
         default:           match_sel = 1'b0;
      endcase
   end

   always_comb begin
      s3_valid_in   = s3_valid_ff;
      s3_address_in = s3_address_ff;
      s3_kept_in    = s3_kept_ff;
      s3_match_in   = s3_match_ff;
      if (s3_ready) begin
         s3_valid_in   = s2_valid_ff;
         s3_address_in = s2_ff.address;
         s3_kept_in    = s2_ff.cur;
         s3_match_in   = match_sel;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      s1_ff         <= s1_in;
      s2_ff         <= s2_in;
      s3_address_ff <= s3_address_in;
      s3_kept_ff    <= s3_kept_in;
      s3_match_ff   <= s3_match_in;
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = RspDataBits'({s3_kept_ff, s3_address_ff});
   assign rsp_tuser  = s3_match_ff;

`ifndef SYNTHESIS
   // An accepted item always lands in stage 1
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted item did not reach stage 1");

   // Input stalls only when stage 1 is occupied
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff)
      else $error("input stalled with stage 1 empty");

   // A blocked compare stage keeps its item and flags
   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s3_ready |=> s2_valid_ff && $stable(s2_ff))
      else $error("stage 2 item lost during stall");

   // A new result only comes from a full compare stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s2_valid_ff))
      else $error("result appeared without an item in stage 2");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/tvsf_csr.sv
// ----------------------------------------------------------------------------
// Value scan filter configuration registers
// Holds mode, width, signedness and the two reference values; written
// through a plain write port, no read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module tvsf_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wen,
   input  wire logic [tvsf_pkg::CsrIndexBits-1:0]  csr_index,
   input  wire logic [tvsf_pkg::CsrDataBits-1:0]   csr_wdata,
   output      tvsf_pkg::cfg_type                  cfg
);
   import tvsf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; unused indexes leave everything as it is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            REG_SCAN_MODE:    cfg_in.scan_mode    = csr_wdata[3:0];
            REG_VALUE_WIDTH:  cfg_in.value_width  = csr_wdata[1:0];
            REG_VALUE_SIGNED: cfg_in.value_signed = csr_wdata[0];
            REG_FIRST_VALUE:  cfg_in.first_value  = csr_wdata;
            REG_SECOND_VALUE: cfg_in.second_value = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_mode    <= MODE_EQUAL;
         cfg_ff.value_width  <= WIDTH_32;
         cfg_ff.value_signed <= 1'b0;
         cfg_ff.first_value  <= 64'd0;
         cfg_ff.second_value <= 64'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Value scan filter testbench
// Streams candidate words through the filter under many register settings
// and checks match flag, address and kept value of every result against an
// in-bench screening function. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module testbench;

   import tvsf_pkg::*;

   localparam int ADDR_BITS  = 48;
   localparam int REQ_BITS   = ((ADDR_BITS + 128 + 7) / 8) * 8;
   localparam int RSP_BITS   = ((ADDR_BITS + 64 + 7) / 8) * 8;
   localparam int PIPE_DEPTH = 3;
   localparam int PHASES     = 36;
   localparam int PHASE_ITEMS = 50;

   typedef struct {
      logic [ADDR_BITS-1:0] address;
      logic [63:0]          current_word;
      logic [63:0]          previous_word;
      logic                 has_previous;
   } candidate_type;

   typedef struct {
      logic                 match;
      logic [ADDR_BITS-1:0] address;
      logic [63:0]          kept_value;
   } verdict_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_BITS-1:0]     req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_BITS-1:0]     rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_wen;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0]  csr_wdata;

   // Register image kept in step with every write
   cfg_type     filter_cfg;
   verdict_type pending_results[$];

   int  hold_off;
   bit  no_idle;
   int  error_count;
   int  items_sent;
   int  results_seen;
   int  match_count;
   int  settings_run;

   typed_value_scan_filter_top #(
      .ADDRESS_BITS(ADDR_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [63:0] lane_mask(input logic [1:0] code);
      case (code)
         WIDTH_8:  return 64'hFF;
         WIDTH_16: return 64'hFFFF;
         WIDTH_32: return 64'hFFFF_FFFF;
         default:  return '1;
      endcase
   endfunction

   // Sign-extend to 64 bits when signed, then flip the top bit so that a
   // plain unsigned compare gives the configured order
   function automatic logic [63:0] rank_of(input logic [63:0] v);
      logic [63:0] ext;
      if (!filter_cfg.value_signed) begin
         return v;
      end
      case (filter_cfg.value_width)
         WIDTH_8:  ext = {{56{v[7]}}, v[7:0]};
         WIDTH_16: ext = {{48{v[15]}}, v[15:0]};
         WIDTH_32: ext = {{32{v[31]}}, v[31:0]};
         default:  ext = v;
      endcase
      return {~ext[63], ext[62:0]};
   endfunction

   // Work out the result for one candidate under the current settings
   function automatic verdict_type screen_candidate(input candidate_type c);
      verdict_type r;
      logic [63:0] mask, cur, prev, lo, hi;
      logic        hit;
      mask = lane_mask(filter_cfg.value_width);
      cur  = c.current_word & mask;
      prev = c.previous_word & mask;
      lo   = filter_cfg.first_value & mask;
      hi   = filter_cfg.second_value & mask;
      case (filter_cfg.scan_mode)
         MODE_EQUAL:        hit = (cur == lo);
         MODE_BIGGER:       hit = rank_of(cur) > rank_of(lo);
         MODE_SMALLER:      hit = rank_of(cur) < rank_of(lo);
         MODE_RANGE:        hit = rank_of(cur) > rank_of(lo) && rank_of(cur) < rank_of(hi);
         MODE_INCREASED:    hit = c.has_previous && rank_of(cur) > rank_of(prev);
         MODE_INCREASED_BY: hit = c.has_previous && (((cur - prev) & mask) == lo);
         MODE_DECREASED:    hit = c.has_previous && rank_of(cur) < rank_of(prev);
         MODE_DECREASED_BY: hit = c.has_previous && (((prev - cur) & mask) == lo);
         MODE_CHANGED:      hit = c.has_previous && (cur != prev);
         MODE_UNCHANGED:    hit = c.has_previous && (cur == prev);
         MODE_UNKNOWN:      hit = 1'b1;
         default:           hit = 1'b0;
      endcase
      r.match      = hit;
      r.address    = c.address;
      r.kept_value = cur;
      return r;
   endfunction

   // Reference values: zero, all ones, signed limits, tiny or random, with
   // junk above the operand width half of the time
   function automatic logic [63:0] pick_reference(input logic [1:0] code);
      logic [63:0] mask, v;
      mask = lane_mask(code);
      case ($urandom_range(0, 5))
         0:       v = '0;
         1:       v = '1;
         2:       v = (mask >> 1) + 64'd1;
         3:       v = mask >> 1;
         4:       v = $urandom_range(0, 3);
         default: v = rand64();
      endcase
      if ($urandom_range(0, 1) == 1) begin
         v = (rand64() & ~mask) | (v & mask);
      end
      return v;
   endfunction

   // Present one item, hold it until taken, then record its expected result
   task automatic send_item(input candidate_type c);
      repeat (hold_off) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {c.previous_word, c.current_word, c.address};
      req_tuser  <= c.has_previous;
      do @(posedge clock); while (!req_tready);
      pending_results.insert(pending_results.size(), screen_candidate(c));
      items_sent++;
      hold_off = draw_wait();
      if (hold_off != 0) begin
         req_tvalid <= 1'b0;
      end
   endtask

   // Drop valid, then wait for every result and let the pipeline settle
   task automatic drain_pipeline();
      if (hold_off == 0) begin
         req_tvalid <= 1'b0;
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexBits-1:0] index,
                                 input logic [63:0] data);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (index)
         REG_SCAN_MODE:    filter_cfg.scan_mode    = data[3:0];
         REG_VALUE_WIDTH:  filter_cfg.value_width  = data[1:0];
         REG_VALUE_SIGNED: filter_cfg.value_signed = data[0];
         REG_FIRST_VALUE:  filter_cfg.first_value  = data;
         REG_SECOND_VALUE: filter_cfg.second_value = data;
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [3:0] mode, input logic [1:0] width,
                                input logic sgn, input logic [63:0] lo,
                                input logic [63:0] hi);
      drain_pipeline();
      write_register(REG_SCAN_MODE, (rand64() & ~64'hF) | 64'(mode));
      write_register(REG_VALUE_WIDTH, (rand64() & ~64'h3) | 64'(width));
      write_register(REG_VALUE_SIGNED, (rand64() & ~64'h1) | 64'(sgn));
      write_register(REG_FIRST_VALUE, lo);
      write_register(REG_SECOND_VALUE, hi);
      settings_run++;
   endtask

   // Accept each result after a random stall and compare it field by field
   initial begin : result_checker
      int          stall;
      verdict_type want;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none actual address %h",
                     $time, rsp_tdata[ADDR_BITS-1:0]);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (want.match) match_count++;
            if (rsp_tuser !== want.match) begin
               $display("%0t: match mismatch: expected %b actual %b",
                        $time, want.match, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[ADDR_BITS-1:0] !== want.address) begin
               $display("%0t: match_address mismatch: expected %h actual %h",
                        $time, want.address, rsp_tdata[ADDR_BITS-1:0]);
               error_count++;
            end
            if (rsp_tdata[ADDR_BITS+63:ADDR_BITS] !== want.kept_value) begin
               $display("%0t: kept_value mismatch: expected %h actual %h",
                        $time, want.kept_value, rsp_tdata[ADDR_BITS+63:ADDR_BITS]);
               error_count++;
            end
         end
      end
   end

   // Registers as they come out of reset: equal to zero at 32 bits unsigned
   task automatic test_reset_defaults();
      candidate_type c;
      c.address       = '1;
      c.current_word  = 64'hFFFF_FFFF_0000_0000;
      c.previous_word = '1;
      c.has_previous  = 1'b0;
      send_item(c);
      c.address       = '0;
      c.current_word  = 64'h0000_0000_0000_0001;
      c.has_previous  = 1'b1;
      send_item(c);
   endtask

   // One item per mode code, undefined codes included, at extreme values
   task automatic test_mode_sweep();
      candidate_type c;
      logic [63:0]   mask;
      logic [1:0]    width;
      for (int code = 0; code < 16; code++) begin
         width = 2'(code);
         mask  = lane_mask(width);
         load_settings(4'(code), width, code[2], (mask >> 1) + 64'd1, mask >> 1);
         c.address       = code[0] ? '1 : '0;
         c.current_word  = code[1] ? '1 : '0;
         c.previous_word = c.current_word - filter_cfg.first_value;
         c.has_previous  = 1'b1;
         send_item(c);
      end
   endtask

   // Modes that need a previous value, given none
   task automatic test_missing_previous();
      candidate_type c;
      for (int code = MODE_INCREASED; code <= MODE_UNCHANGED; code++) begin
         load_settings(4'(code), WIDTH_64, 1'b0, 64'd0, 64'd0);
         c.address       = ADDR_BITS'(rand64());
         c.current_word  = 64'd5;
         c.previous_word = code[0] ? 64'd5 : 64'd2;
         c.has_previous  = 1'b0;
         send_item(c);
      end
   endtask

   // Per phase: mode from the phase number, other settings mostly random; items biased toward the compare edges
   task automatic test_random_phases();
      candidate_type c;
      logic [63:0]   mask, target, raw;
      logic [1:0]    width;
      for (int phase = 0; phase < PHASES; phase++) begin
         width = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
         load_settings(4'(phase), width, 1'($urandom_range(0, 1)),
                       pick_reference(width), pick_reference(width));
         no_idle = (phase % 5 == 3);
         mask    = lane_mask(width);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold the sender until the pipeline has emptied
            if (n == PHASE_ITEMS / 2 && phase % 4 == 1) begin
               drain_pipeline();
            end
            raw             = rand64();
            c.address       = ADDR_BITS'(rand64());
            c.previous_word = rand64();
            c.has_previous  = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 7))
               0: target = filter_cfg.first_value;
               1: target = c.previous_word + filter_cfg.first_value;
               2: target = c.previous_word - filter_cfg.first_value;
               3: target = c.previous_word;
               4: target = filter_cfg.first_value + ($urandom_range(0, 1) ? 64'd1 : '1);
               5: target = filter_cfg.second_value + ($urandom_range(0, 1) ? 64'd1 : '1);
               default: target = raw;
            endcase
            c.current_word = (raw & ~mask) | (target & mask);
            send_item(c);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      filter_cfg = '{scan_mode: MODE_EQUAL, value_width: WIDTH_32, value_signed: 1'b0,
                     first_value: 64'd0, second_value: 64'd0};
      hold_off     = 0;
      no_idle      = 1'b0;
      error_count  = 0;
      items_sent   = 0;
      results_seen = 0;
      match_count  = 0;
      settings_run = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_mode_sweep();
      test_missing_previous();
      test_random_phases();
      drain_pipeline();
      repeat (4 * PIPE_DEPTH) @(posedge clock);

      $display("Ran %0d candidates under %0d register settings; %0d results, %0d matches.",
               items_sent, settings_run, results_seen, match_count);
      $display("All mode codes, undefined ones too, at widths 8 to 64, signed and unsigned.");
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
